// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache; no dependencies.
`default_nettype none

package lkv_pkg;

  // Field widths
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CAP_W = 5;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_CAPACITY = 1'b0;   // word index of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Kind of table update done in the update cycle
  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_TOUCH = 2'd1,
    UPD_FILL  = 2'd2,
    UPD_EVICT = 2'd3
  } upd_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_COMPARE = 2'd1,
    S_UPDATE  = 2'd2,
    S_RESPOND = 2'd3
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // latch the input beat
    logic capture;   // register the key match vector
    logic update;    // update cycle: table write and value read
    upd_e upd_op;
    logic respond;   // result beat on the ports
  } lkv_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic is_put;
    logic has_room;
  } lkv_status_t;

endpackage

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// LRU key/value cache: 1 to ENTRIES entries, get/put commands, capacity register.
// The result strobe done_o is high in the respond step, after the compare and update steps.
// A new beat is taken once the previous one reaches respond; compare, update and respond run in turn.
// The receiver cannot stall; each result beat is on the ports for one cycle only.
// Reset clears all entries (valid bits, ranks, fill count) at once and sets capacity to 16.
// Depends on lkv_pkg, lkv_ctrl, lkv_datapath and lkv_ram.
`default_nettype none

module lru_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Command channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         command_i,
  input  wire logic [lkv_pkg::KEY_W-1:0]    key_i,
  input  wire logic [lkv_pkg::VAL_W-1:0]    value_i,
  // Result channel
  output logic                              done_o,
  output logic                              found_o,
  output logic      [lkv_pkg::VAL_W-1:0]    read_value_o,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lkv_pkg::APB_AW-1:0]   paddr,
  input  wire logic [lkv_pkg::APB_DW-1:0]   pwdata,
  output logic      [lkv_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);

  import lkv_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  lkv_cmd_t         cmd;
  lkv_status_t      status;

  // Capacity register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

  lkv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  lkv_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .command_i    (command_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .cap_i        (cap_q),
    .found_o      (found_o),
    .read_value_o (read_value_o)
  );

  // A capacity write lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cfg_wr && (paddr[2] == REG_CAPACITY)) |=> cap_q == $past(pwdata[CAP_W-1:0]))
    else $error("capacity write lost");

endmodule

`default_nettype wire

// ===== rtl/lkv_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module lkv_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/lkv_ctrl.sv =====
// Sequencing state machine of the LRU cache: compare, update, respond.
// Depends on lkv_pkg.
`default_nettype none

module lkv_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      done_o,
  input  wire lkv_pkg::lkv_status_t status_i,
  output lkv_pkg::lkv_cmd_t         cmd_o
);

  import lkv_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new beat may enter while the previous result is on the ports
  assign busy   = (state_q == S_COMPARE) || (state_q == S_UPDATE);
  assign accept = start && !busy;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.upd_op   = UPD_NONE;
    cmd_o.load     = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_COMPARE;
      end
      S_COMPARE: begin
        cmd_o.capture = 1'b1;
        state_d       = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.hit) begin
          cmd_o.upd_op = UPD_TOUCH;
        end else if (status_i.is_put) begin
          cmd_o.upd_op = status_i.has_room ? UPD_FILL : UPD_EVICT;
        end
        state_d = S_RESPOND;
      end
      S_RESPOND: begin
        cmd_o.respond = 1'b1;
        state_d       = accept ? S_COMPARE : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o = cmd_o.respond;

  // Every accepted beat gets its result strobe in the respond state after its compare and update states
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> ##2 done_o)
    else $error("result strobe missing after accepted beat");

endmodule

`default_nettype wire

// ===== rtl/lkv_datapath.sv =====
// Datapath of the LRU cache: key CAM, valid bits, recency ranks, value RAM.
// Depends on lkv_pkg and lkv_ram.
`default_nettype none

module lkv_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lkv_pkg::lkv_cmd_t           cmd_i,
  output lkv_pkg::lkv_status_t             status_o,
  input  wire logic                        command_i,
  input  wire logic [lkv_pkg::KEY_W-1:0]   key_i,
  input  wire logic [lkv_pkg::VAL_W-1:0]   value_i,
  input  wire logic [lkv_pkg::CAP_W-1:0]   cap_i,
  output logic                             found_o,
  output logic      [lkv_pkg::VAL_W-1:0]   read_value_o
);

  import lkv_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned UW = $clog2(ENTRIES + 1);

  // Input beat
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Table state
  logic [KEY_W-1:0]   keys_q [ENTRIES];
  logic [RW-1:0]      rank_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [UW-1:0]      used_q;
  logic [ENTRIES-1:0] match_q;

  // Result flags
  logic found_q, rd_sel_q;

  logic [ENTRIES-1:0] match_d, free_oh, lru_oh, tgt_oh;
  logic [RW-1:0]      tgt_rank;
  logic [IW-1:0]      tgt_idx;
  logic [UW-1:0]      cap_eff;
  logic [VAL_W-1:0]   rdata;
  logic               ram_we, ram_re;

  // Input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  // Parallel key compare
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i] = valid_q[i] && (keys_q[i] == key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else if (cmd_i.capture) begin
      match_q <= match_d;
    end
  end

  // Capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = UW'(1);
    end else if (int'(cap_i) > int'(ENTRIES)) begin
      cap_eff = UW'(ENTRIES);
    end else begin
      cap_eff = UW'(cap_i);
    end
  end

  assign status_o.hit      = |match_q;
  assign status_o.is_put   = (cmd_q == OP_PUT);
  assign status_o.has_room = used_q < cap_eff;

  // Lowest free entry and least recent valid entry, both one-hot
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lru_oh[i] = valid_q[i] && (UW'(rank_q[i]) == (used_q - UW'(1)));
    end
  end

  // Target entry of the update
  always_comb begin
    case (cmd_i.upd_op)
      UPD_TOUCH: tgt_oh = match_q;
      UPD_FILL:  tgt_oh = free_oh;
      UPD_EVICT: tgt_oh = lru_oh;
      default:   tgt_oh = '0;
    endcase
  end

  always_comb begin
    tgt_rank = '0;
    tgt_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt_oh[i]) begin
        tgt_rank = tgt_rank | rank_q[i];
        tgt_idx  = tgt_idx | IW'(i);
      end
    end
  end

  // Rank, valid and fill count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update && (cmd_i.upd_op != UPD_NONE)) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tgt_oh[i]) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] &&
                     ((cmd_i.upd_op == UPD_FILL) || (rank_q[i] < tgt_rank))) begin
          rank_q[i] <= rank_q[i] + RW'(1);
        end
      end
      if (cmd_i.upd_op == UPD_FILL) begin
        valid_q <= valid_q | free_oh;
        used_q  <= used_q + UW'(1);
      end
    end
  end

  // Key store, written on fill and eviction
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.update && tgt_oh[i] &&
          ((cmd_i.upd_op == UPD_FILL) || (cmd_i.upd_op == UPD_EVICT))) begin
        keys_q[i] <= key_q;
      end
    end
  end

  // Value store: put writes, get hit reads
  assign ram_we = cmd_i.update && (cmd_q == OP_PUT) && (cmd_i.upd_op != UPD_NONE);
  assign ram_re = cmd_i.update && (cmd_q == OP_GET) && (cmd_i.upd_op == UPD_TOUCH);

  lkv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (tgt_idx),
    .wdata_i (val_q),
    .rdata_o (rdata)
  );

  // Result flags for the respond cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      rd_sel_q <= 1'b0;
    end else if (cmd_i.update) begin
      found_q  <= status_o.hit;
      rd_sel_q <= ram_re;
    end
  end

  assign found_o      = found_q;
  assign read_value_o = rd_sel_q ? rdata : '0;

  // Fill count tracks the valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $countones(valid_q) == int'(used_q))
    else $error("fill count disagrees with valid entries");

  // Keys stay unique, so at most one entry matches
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(match_q))
    else $error("key present in more than one entry");

  // An eviction always finds its least recent entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_i.update && (cmd_i.upd_op == UPD_EVICT)) |-> $onehot(lru_oh))
    else $error("no unique least recent entry on eviction");

endmodule

`default_nettype wire
